// ===== hdl/xxrf_pkg.sv =====
// ----------------------------------------------------------------------------
// XON/XOFF receive FIFO package
// Shared types, codes and default values for the receive FIFO with
// XON/XOFF flow control.
// ----------------------------------------------------------------------------
package xxrf_pkg;

   localparam int DEPTH_DEFAULT = 8;

   localparam logic [7:0] UPPER_LIMIT_RESET = 8'd7;
   localparam logic [7:0] LOWER_LIMIT_RESET = 8'd5;
   localparam logic [7:0] END_MARKER_RESET  = 8'd26;

   localparam logic       CMD_PUSH = 1'b0;
   localparam logic       CMD_POP  = 1'b1;

   localparam logic [1:0] FLOW_NONE = 2'd0;
   localparam logic [1:0] FLOW_XOFF = 2'd1;
   localparam logic [1:0] FLOW_XON  = 2'd2;

   localparam logic [1:0] CSR_UPPER_LIMIT = 2'd0;
   localparam logic [1:0] CSR_LOWER_LIMIT = 2'd1;
   localparam logic [1:0] CSR_END_MARKER  = 2'd2;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] flow_request;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       empty_flag;
      logic       end_seen;
      logic       dropped;
      logic [3:0] fill_level;
   } rsp_type;

   typedef struct packed {
      logic [7:0] upper_limit;
      logic [7:0] lower_limit;
      logic [7:0] end_marker;
   } cfg_type;

endpackage

// ===== hdl/xxrf_csr.sv =====
// ----------------------------------------------------------------------------
// XON/XOFF receive FIFO control registers
// Holds the flow control limits and the end-of-file marker.
// ----------------------------------------------------------------------------
module xxrf_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [7:0]       csr_wdata,
   output xxrf_pkg::cfg_type cfg
);
   import xxrf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_UPPER_LIMIT: cfg_in.upper_limit = csr_wdata;
            CSR_LOWER_LIMIT: cfg_in.lower_limit = csr_wdata;
            CSR_END_MARKER:  cfg_in.end_marker  = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.upper_limit <= UPPER_LIMIT_RESET;
         cfg_ff.lower_limit <= LOWER_LIMIT_RESET;
         cfg_ff.end_marker  <= END_MARKER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/xxrf_core.sv =====
// ----------------------------------------------------------------------------
// XON/XOFF receive FIFO core
// Ring buffer state, flow control decision and result register. The head
// word is read ahead into a register so that a pop finds it ready.
// ----------------------------------------------------------------------------
module xxrf_core #(
   parameter int DEPTH = xxrf_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  xxrf_pkg::req_type in_data,
   input  xxrf_pkg::cfg_type cfg,
   output logic              out_valid,
   output xxrf_pkg::rsp_type out_data
);
   import xxrf_pkg::*;

   localparam int IdxW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);
   localparam int CmpW = (CntW > 8) ? CntW : 8;

   logic [7:0]      mem [DEPTH];
   logic [7:0]      head_word_ff;
   logic [IdxW-1:0] head_ff, head_in;
   logic [IdxW-1:0] tail_ff, tail_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            paused_ff, paused_in;
   logic            wr_en;
   logic            out_valid_ff;
   rsp_type         out_data_ff, out_data_in;
   logic            at_upper, at_lower;

   function automatic logic [IdxW-1:0] next_slot(input logic [IdxW-1:0] idx);
      logic [IdxW-1:0] nxt;
      nxt = (idx == IdxW'(DEPTH - 1)) ? '0 : idx + 1'b1;
      return nxt;
   endfunction

   assign at_upper = CmpW'(count_ff) >= CmpW'(cfg.upper_limit);
   assign at_lower = CmpW'(count_ff) <= CmpW'(cfg.lower_limit);

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      paused_in   = paused_ff;
      wr_en       = 1'b0;
      out_data_in = '0;
      if (in_valid) begin
         if (in_data.cmd == CMD_PUSH) begin
            if (at_upper && !paused_ff) begin
               out_data_in.flow_request = FLOW_XOFF;
               paused_in                = 1'b1;
            end
            if (in_data.rx_byte == cfg.end_marker) begin
               out_data_in.end_seen = 1'b1;
            end else if (count_ff == CntW'(DEPTH)) begin
               out_data_in.dropped = 1'b1;
            end else begin
               wr_en    = 1'b1;
               tail_in  = next_slot(tail_ff);
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (count_ff == '0) begin
               out_data_in.empty_flag = 1'b1;
            end else begin
               if (at_lower && paused_ff) begin
                  out_data_in.flow_request = FLOW_XON;
                  paused_in                = 1'b0;
               end
               out_data_in.read_byte  = head_word_ff;
               out_data_in.read_valid = 1'b1;
               head_in                = next_slot(head_ff);
               count_in               = count_ff - 1'b1;
            end
         end
      end
      out_data_in.fill_level = 4'(count_in);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= in_data.rx_byte;
      end
      if (wr_en && (tail_ff == head_in)) begin
         head_word_ff <= in_data.rx_byte;
      end else begin
         head_word_ff <= mem[head_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         paused_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         paused_ff    <= paused_in;
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ===== hdl/xon_xoff_receive_fifo_unit.sv =====
// ----------------------------------------------------------------------------
// XON/XOFF receive FIFO unit
// Receive byte FIFO that asks the sender to pause (XOFF) and resume (XON)
// with hysteresis between an upper and a lower fill limit.
//
//   Channel   Direction  Handshake          Word
//   command   in         start, busy        req_data  (cmd, rx_byte)
//   result    out        rsp_valid strobe   rsp_data  (flags, byte, level)
//   control   in         csr_we             csr_index, csr_wdata
//
// One command word is taken every cycle; its result is registered first
// in the input register and then in the result register, around the
// single stage of FIFO logic. Busy is never raised.
// Reset is synchronous; the buffer needs no clearing.
// The result strobe lasts one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module xon_xoff_receive_fifo_unit #(
   parameter int DEPTH = xxrf_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  xxrf_pkg::req_type req_data,
   output logic              rsp_valid,
   output xxrf_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);
   import xxrf_pkg::*;

   logic    in_valid_ff;
   req_type in_data_ff;
   cfg_type cfg;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         in_data_ff <= req_data;
      end
   end

   xxrf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   xxrf_core #(
      .DEPTH (DEPTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_data   (in_data_ff),
      .cfg       (cfg),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("Accepted word produced no result two cycles later.");

   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_data.read_valid, rsp_data.empty_flag,
                              rsp_data.end_seen, rsp_data.dropped}))
      else $error("Result carries more than one outcome.");

   a_flow_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.flow_request != 2'd3))
      else $error("Undefined flow request code.");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.dropped) |-> (rsp_data.fill_level == 4'(DEPTH)))
      else $error("Word dropped while the buffer was not full.");

endmodule
